[rtl/sdq_pkg.sv]
// Package for the sorted double-ended queue: command and status codes,
// and the control word that the top level broadcasts to every cell.
// No dependencies.
package sdq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MIN = 2'd1,
    CMD_POP_MAX = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control word seen by all cells in the cycle a request is accepted.
  typedef struct packed {
    logic               ins;      // insert that fits
    logic               pop_min;  // remove smallest from a non-empty store
    logic [VALUE_W-1:0] value;    // value being inserted
  } cell_ctrl_t;

endpackage

[rtl/sdq_cell.sv]
// One storage cell of the sorted queue: a value register plus the
// compare-and-shift logic that talks to its two neighbors. Uses sdq_pkg.
module sdq_cell (
  input  logic                             clk,
  input  sdq_pkg::cell_ctrl_t              ctrl,
  input  logic                             valid,
  input  logic [sdq_pkg::VALUE_W-1:0]      left_value,
  input  logic                             left_greater,
  input  logic [sdq_pkg::VALUE_W-1:0]      right_value,
  output logic [sdq_pkg::VALUE_W-1:0]      value,
  output logic                             greater
);

  logic [sdq_pkg::VALUE_W-1:0] value_r;
  logic [sdq_pkg::VALUE_W-1:0] value_nxt;

  // An empty cell counts as greater, so the flags rise once along the row.
  assign greater = !valid || ($signed(value_r) > $signed(ctrl.value));
  assign value   = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (greater) begin
        value_nxt = left_greater ? left_value : ctrl.value;
      end
    end else if (ctrl.pop_min) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[rtl/sorted_double_ended_queue.sv]
// Sorted double-ended queue: top level with the row of cells, the count and
// the result register. Depends on sdq_pkg and sdq_cell.
// The result is registered: it appears in the cycle after the request is accepted.
// Throughput: one request per cycle; busy stays low, as every command is
// decoded and applied to the cell row in the cycle it is accepted.
// Reset (rst_n low, synchronous) empties the store and drops any pending result.
// The receiver cannot stall: out_valid is high for exactly one cycle per request.
module sorted_double_ended_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdq_pkg::CMD_W-1:0]     in_command,
  input  logic [sdq_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  output logic [sdq_pkg::VALUE_W-1:0]   out_result_value,
  output logic [sdq_pkg::STATUS_W-1:0]  out_status,
  output logic [sdq_pkg::COUNT_W-1:0]   out_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Every command is applied in the cycle it is accepted, so the block never refuses a request.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                          out_valid_r;
  logic [sdq_pkg::VALUE_W-1:0]   out_result_value_r;
  logic [sdq_pkg::VALUE_W-1:0]   out_result_value_nxt;
  logic [sdq_pkg::STATUS_W-1:0]  out_status_r;
  logic [sdq_pkg::STATUS_W-1:0]  out_status_nxt;
  logic [sdq_pkg::COUNT_W-1:0]   out_count_r;

  sdq_pkg::cmd_t        cmd;
  sdq_pkg::cell_ctrl_t  ctrl;
  logic                 full;
  logic                 empty;

  assign cmd   = sdq_pkg::cmd_t'(in_command);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // The cell row: each cell holds one entry, entries below count_r are valid
  // and sorted ascending from cell 0. On an insert, every cell holding a value
  // greater than the new one takes its left neighbor's value, and the first of
  // those takes the new value; duplicates therefore land after equal entries.
  // Removing the smallest shifts the whole row one place to the left.
  logic [sdq_pkg::VALUE_W-1:0] cell_value   [CAPACITY];
  logic                        cell_greater [CAPACITY];
  logic                        cell_valid   [CAPACITY];

  // The largest entry sits in cell count_r-1; its value is picked out by an
  // AND-OR reduction along the row for the remove-largest command.
  logic [sdq_pkg::VALUE_W-1:0] top_acc [CAPACITY+1];
  assign top_acc[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sdq_pkg::VALUE_W-1:0] left_value;
    logic                        left_greater;
    logic [sdq_pkg::VALUE_W-1:0] right_value;
    logic                        is_top;

    assign cell_valid[i] = (CNT_W'(i) < count_r);
    assign is_top        = (CNT_W'(i + 1) == count_r);
    assign top_acc[i+1]  = top_acc[i] | (is_top ? cell_value[i] : '0);

    if (i == 0) begin : g_first
      assign left_value   = '0;
      assign left_greater = 1'b0;
    end else begin : g_inner
      assign left_value   = cell_value[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sdq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .valid        (cell_valid[i]),
      .left_value   (left_value),
      .left_greater (left_greater),
      .right_value  (right_value),
      .value        (cell_value[i]),
      .greater      (cell_greater[i])
    );
  end

  // Decode the request into the broadcast control word, the new count and
  // the result fields.
  always_comb begin
    ctrl.ins             = 1'b0;
    ctrl.pop_min         = 1'b0;
    ctrl.value           = in_value;
    count_nxt            = count_r;
    out_result_value_nxt = '0;
    out_status_nxt       = sdq_pkg::ST_OK;
    if (accept) begin
      unique case (cmd)
        sdq_pkg::CMD_INSERT: begin
          if (full) begin
            out_status_nxt = sdq_pkg::ST_FULL;
          end else begin
            ctrl.ins             = 1'b1;
            count_nxt            = count_r + 1'b1;
            out_result_value_nxt = in_value;
          end
        end
        sdq_pkg::CMD_POP_MIN: begin
          if (empty) begin
            out_status_nxt = sdq_pkg::ST_EMPTY;
          end else begin
            ctrl.pop_min         = 1'b1;
            count_nxt            = count_r - 1'b1;
            out_result_value_nxt = cell_value[0];
          end
        end
        sdq_pkg::CMD_POP_MAX: begin
          if (empty) begin
            out_status_nxt = sdq_pkg::ST_EMPTY;
          end else begin
            count_nxt            = count_r - 1'b1;
            out_result_value_nxt = top_acc[CAPACITY];
          end
        end
        sdq_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload needs no reset; it is only looked at under out_valid.
  always_ff @(posedge clk) begin
    out_result_value_r <= out_result_value_nxt;
    out_status_r       <= out_status_nxt;
    out_count_r        <= sdq_pkg::COUNT_W'(count_nxt);
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;

  // Assertions.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request gave no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a request");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sdq_pkg::ST_FULL) |->
      (out_count == sdq_pkg::COUNT_W'(CAPACITY) && out_result_value == '0))
    else $error("full status with wrong count or value");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sdq_pkg::ST_EMPTY) |->
      (out_count == '0 && out_result_value == '0))
    else $error("empty status with nonzero count or value");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted double-ended queue. A directed table
// and then random requests are checked against a shadow copy of the sorted store.
// Depends on sdq_pkg and the sorted_double_ended_queue top level.
module tb_top;

  localparam int unsigned CAPACITY        = 16;
  localparam int unsigned RANDOM_REQUESTS = 800;
  // The block answers in the cycle after a request. The slowest legal run is about
  // 830 requests, each after the longest gap send_request draws. The limit is many times that.
  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned DIRECTED_ROWS   = 26;

  // One result of the store, as the block reports it.
  typedef struct packed {
    logic [sdq_pkg::VALUE_W-1:0] value;
    sdq_pkg::status_t            status;
    logic [sdq_pkg::COUNT_W-1:0] count;
  } store_result_t;

  // One request. When pinned is set, the result is typed in by hand in pin
  // and is used in place of the shadow store's prediction.
  typedef struct packed {
    sdq_pkg::cmd_t               cmd;
    logic [sdq_pkg::VALUE_W-1:0] value;
    logic                        pinned;
    store_result_t               pin;
  } store_request_t;

  logic                         clk;
  logic                         rst_n            = 1'b0;
  logic                         start            = 1'b0;
  logic                         busy;
  logic [sdq_pkg::CMD_W-1:0]    in_command       = '0;
  logic [sdq_pkg::VALUE_W-1:0]  in_value         = '0;
  logic                         out_valid;
  logic [sdq_pkg::VALUE_W-1:0]  out_result_value;
  logic [sdq_pkg::STATUS_W-1:0] out_status;
  logic [sdq_pkg::COUNT_W-1:0]  out_count;

  // Shadow store: the sorted entries and how many are valid. Only entries
  // below shadow_count are ever read.
  logic [sdq_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
  int                          shadow_count = 0;

  store_request_t pending_requests [$];  // Raised on start but not yet accepted.
  store_result_t  awaited_results [$];   // Accepted, and the result not yet seen.
  int             errors = 0;
  int             cycle_count = 0;
  bit             quiet = 1'b0;          // When set, requests go back to back.

  // The directed part. It covers removal and clear on an empty store, the
  // extreme values, a duplicate, filling to capacity, an insert into a full
  // store, removal from both ends, and a removal after a clear.
  store_request_t directed_table [DIRECTED_ROWS] = '{
    '{sdq_pkg::CMD_POP_MIN, 32'hDEADBEEF, 1'b1, '{32'h00000000, sdq_pkg::ST_EMPTY, 5'd0}},
    '{sdq_pkg::CMD_POP_MAX, 32'h00000000, 1'b1, '{32'h00000000, sdq_pkg::ST_EMPTY, 5'd0}},
    '{sdq_pkg::CMD_CLEAR,   32'hFFFFFFFF, 1'b1, '{32'h00000000, sdq_pkg::ST_OK,    5'd0}},
    '{sdq_pkg::CMD_INSERT,  32'h7FFFFFFF, 1'b1, '{32'h7FFFFFFF, sdq_pkg::ST_OK,    5'd1}},
    '{sdq_pkg::CMD_INSERT,  32'h80000000, 1'b1, '{32'h80000000, sdq_pkg::ST_OK,    5'd2}},
    '{sdq_pkg::CMD_INSERT,  32'h00000000, 1'b1, '{32'h00000000, sdq_pkg::ST_OK,    5'd3}},
    '{sdq_pkg::CMD_INSERT,  32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, sdq_pkg::ST_OK,    5'd4}},
    '{sdq_pkg::CMD_INSERT,  32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, sdq_pkg::ST_OK,    5'd5}},
    '{sdq_pkg::CMD_INSERT,  32'h00000001, 1'b1, '{32'h00000001, sdq_pkg::ST_OK,    5'd6}},
    '{sdq_pkg::CMD_INSERT,  32'h55555555, 1'b1, '{32'h55555555, sdq_pkg::ST_OK,    5'd7}},
    '{sdq_pkg::CMD_INSERT,  32'hAAAAAAAA, 1'b1, '{32'hAAAAAAAA, sdq_pkg::ST_OK,    5'd8}},
    '{sdq_pkg::CMD_INSERT,  32'h12345678, 1'b1, '{32'h12345678, sdq_pkg::ST_OK,    5'd9}},
    '{sdq_pkg::CMD_INSERT,  32'hFEDCBA98, 1'b1, '{32'hFEDCBA98, sdq_pkg::ST_OK,    5'd10}},
    '{sdq_pkg::CMD_INSERT,  32'hFFFFFFFE, 1'b1, '{32'hFFFFFFFE, sdq_pkg::ST_OK,    5'd11}},
    '{sdq_pkg::CMD_INSERT,  32'h00000002, 1'b1, '{32'h00000002, sdq_pkg::ST_OK,    5'd12}},
    '{sdq_pkg::CMD_INSERT,  32'h7FFFFFFE, 1'b1, '{32'h7FFFFFFE, sdq_pkg::ST_OK,    5'd13}},
    '{sdq_pkg::CMD_INSERT,  32'h80000001, 1'b1, '{32'h80000001, sdq_pkg::ST_OK,    5'd14}},
    '{sdq_pkg::CMD_INSERT,  32'h00000064, 1'b1, '{32'h00000064, sdq_pkg::ST_OK,    5'd15}},
    '{sdq_pkg::CMD_INSERT,  32'hFFFFFF9C, 1'b1, '{32'hFFFFFF9C, sdq_pkg::ST_OK,    5'd16}},
    '{sdq_pkg::CMD_INSERT,  32'h00000005, 1'b1, '{32'h00000000, sdq_pkg::ST_FULL,  5'd16}},
    '{sdq_pkg::CMD_POP_MIN, 32'h00000000, 1'b1, '{32'h80000000, sdq_pkg::ST_OK,    5'd15}},
    '{sdq_pkg::CMD_POP_MAX, 32'h00000000, 1'b1, '{32'h7FFFFFFF, sdq_pkg::ST_OK,    5'd14}},
    '{sdq_pkg::CMD_POP_MIN, 32'hFFFFFFFF, 1'b0, '{32'h00000000, sdq_pkg::ST_OK,    5'd0}},
    '{sdq_pkg::CMD_POP_MAX, 32'h12345678, 1'b0, '{32'h00000000, sdq_pkg::ST_OK,    5'd0}},
    '{sdq_pkg::CMD_CLEAR,   32'h00000000, 1'b1, '{32'h00000000, sdq_pkg::ST_OK,    5'd0}},
    '{sdq_pkg::CMD_POP_MAX, 32'h00000000, 1'b1, '{32'h00000000, sdq_pkg::ST_EMPTY, 5'd0}}
  };

  sorted_double_ended_queue #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the shadow store and returns the result the block
  // must give. An insert goes after every stored value that is not greater
  // than it, so duplicates land behind their equals.
  function automatic store_result_t predict_store_result(
    sdq_pkg::cmd_t cmd,
    logic [sdq_pkg::VALUE_W-1:0] val
  );
    store_result_t r;
    int            slot;
    r.value  = '0;
    r.status = sdq_pkg::ST_OK;
    case (cmd)
      sdq_pkg::CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_count && !($signed(shadow_entries[slot]) > $signed(val)))
            slot++;
          for (int i = shadow_count; i > slot; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = val;
          shadow_count++;
          r.value = val;
        end
      end
      sdq_pkg::CMD_POP_MIN: begin
        if (shadow_count == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else begin
          r.value = shadow_entries[0];
          for (int i = 1; i < shadow_count; i++)
            shadow_entries[i-1] = shadow_entries[i];
          shadow_count--;
        end
      end
      sdq_pkg::CMD_POP_MAX: begin
        if (shadow_count == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else begin
          r.value = shadow_entries[shadow_count-1];
          shadow_count--;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    r.count = sdq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // Values lean toward a narrow band around zero so that duplicates and equal
  // neighbors are common. Values near both ends of the signed range are mixed in.
  function automatic logic [sdq_pkg::VALUE_W-1:0] draw_value();
    logic [sdq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      4, 5, 6: v = sdq_pkg::VALUE_W'($urandom_range(0, 16)) - sdq_pkg::VALUE_W'(8);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h80000000;
          1:       v = 32'h7FFFFFFF;
          2:       v = 32'h00000000;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      8: v = $urandom_range(0, 1) ? 32'h80000000 + sdq_pkg::VALUE_W'($urandom_range(0, 3))
                                  : 32'h7FFFFFFF - sdq_pkg::VALUE_W'($urandom_range(0, 3));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // The mix of commands follows the current phase: 0 fills the store and runs
  // into full, 1 drains it and runs into empty, and 2 keeps it near the middle.
  // A clear turns up now and then in every phase.
  function automatic sdq_pkg::cmd_t draw_command(int phase);
    int pick;
    int insert_share;
    pick = $urandom_range(0, 99);
    insert_share = (phase == 0) ? 80 : (phase == 1) ? 25 : 50;
    if (pick < 3)
      return sdq_pkg::CMD_CLEAR;
    else if (pick < 3 + insert_share)
      return sdq_pkg::CMD_INSERT;
    else
      return $urandom_range(0, 1) ? sdq_pkg::CMD_POP_MIN : sdq_pkg::CMD_POP_MAX;
  endfunction

  // Sends one request. The task is entered at a rising edge and returns at the
  // edge where the request was accepted. start is lowered only if a gap
  // follows, so it is assigned at most once in any time step.
  task automatic send_request(store_request_t req);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= req.cmd;
    in_value   <= req.value;
    pending_requests.push_back(req);
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Stimulus: reset, the directed table, the random part, then the drain.
  initial begin
    store_request_t req;
    int             phase;
    phase = 2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      quiet = (row >= 20);
      send_request(directed_table[row]);
    end

    // The random part works in stretches of 40 requests. Each stretch picks a
    // phase and decides whether the requests come with gaps or back to back.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        phase = $urandom_range(0, 2);
      end
      req        = '0;
      req.cmd    = draw_command(phase);
      req.value  = draw_value();
      send_request(req);
    end
    start <= 1'b0;

    // Wait until every accepted request has its result. Then allow a few more
    // cycles so that any result with no request behind it gets caught.
    while (pending_requests.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Monitor and checker. Everything is sampled at the rising edge, before the
  // edge's nonblocking updates, so each signal shows the value it held in the
  // cycle that the edge closes. The result is checked before the newly
  // accepted request is queued. The block registers its answer, so it never
  // shows up in the same edge's result.
  always @(posedge clk) begin
    store_result_t  want;
    store_result_t  predicted;
    store_request_t sent;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request outstanding: value %h status %0d count %0d",
                   $time, out_result_value, out_status, out_count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_result_value !== want.value) begin
            $display("%0t: result value mismatch: expected %h actual %h",
                     $time, want.value, out_result_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
          if (out_count !== want.count) begin
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count, out_count);
            errors++;
          end
        end
      end

      // A request is accepted here. The shadow store always moves forward.
      // A hand-typed result from the table takes the place of the prediction.
      if (start === 1'b1 && busy === 1'b0) begin
        predicted = predict_store_result(sdq_pkg::cmd_t'(in_command), in_value);
        if (pending_requests.size() != 0) begin
          sent = pending_requests.pop_front();
          if (sent.pinned)
            predicted = sent.pin;
        end
        awaited_results.push_back(predicted);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
    end
  end

endmodule

[sorted_double_ended_queue.f]
rtl/sdq_pkg.sv
rtl/sdq_cell.sv
rtl/sorted_double_ended_queue.sv
tb/tb_top.sv
